@@ design/lsd_pkg.sv @@
// lsd_pkg: sizes, sequencer states and register codes of the lsd radix sorter
// no dependencies; imported by lsd_radix_sorter_top
package lsd_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 32;
    localparam int MAX_RADIX  = 256;
    localparam int MAX_PASSES = 4;

    localparam int ADDR_W   = $clog2(MAX_ITEMS);
    localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
    localparam int DIGIT_W  = $clog2(MAX_RADIX);
    localparam int BITS_W   = $clog2(DIGIT_W + 1);
    localparam int PASS_W   = $clog2(MAX_PASSES + 1);
    localparam int SHIFT_W  = $clog2(MAX_PASSES * DIGIT_W + 1);
    localparam int IDX_MAX  = (MAX_RADIX > MAX_ITEMS) ? MAX_RADIX : MAX_ITEMS;
    localparam int IDX_W    = $clog2(IDX_MAX + 1);

    localparam int DATA_W     = 32;
    localparam int CFG_PASS_W = 3;
    localparam int CFG_BITS_W = 4;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    typedef logic [0:0] reg_idx_t;
    localparam reg_idx_t REG_DIGIT_PASSES = 1'b0;
    localparam reg_idx_t REG_DIGIT_BITS   = 1'b1;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_CNT_RE,
        ST_CNT_RC,
        ST_CNT_WR,
        ST_PFX_RD,
        ST_PFX_WR,
        ST_SC_RE,
        ST_SC_RC,
        ST_SC_WR,
        ST_CP_RD,
        ST_CP_WR,
        ST_PASS,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WAIT
    } state_t;

    // bits per digit after clamping to 1 .. DIGIT_W
    function automatic logic [BITS_W-1:0] eff_bits(input logic [CFG_BITS_W-1:0] b);
        logic [BITS_W-1:0] r;
        if (b == '0) begin
            r = BITS_W'(1);
        end else if (int'(b) > DIGIT_W) begin
            r = BITS_W'(DIGIT_W);
        end else begin
            r = BITS_W'(b);
        end
        return r;
    endfunction

    function automatic logic [PASS_W-1:0] eff_passes(input logic [CFG_PASS_W-1:0] p);
        logic [PASS_W-1:0] r;
        if (int'(p) > MAX_PASSES) begin
            r = PASS_W'(MAX_PASSES);
        end else begin
            r = PASS_W'(p);
        end
        return r;
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_mask(input logic [BITS_W-1:0] b);
        logic [DIGIT_W-1:0] m;
        for (int j = 0; j < DIGIT_W; j++) begin
            m[j] = (j < int'(b));
        end
        return m;
    endfunction

endpackage

@@ design/lsd_radix_sorter_top.sv @@
// lsd_radix_sorter_top: least-significant-digit radix sorter with stream ports and apb config
// depends on lsd_pkg
//
// Words are loaded one per cycle into a 64-entry element store until a word with tlast
// arrives; words beyond 64 are dropped and every output word of that run carries tuser=1.
// Input is then held off while a small sequencer runs the configured digit passes through
// one shared 7-bit adder and count, element and copy memories with one read and one write
// port each. With radix R = 2^digit_bits, each pass runs count table clear, count, prefix
// sum, scatter and copy back in turn. Each output word is read from the element store into
// the output register and held until m_tready; the final word has tlast set, after which
// the block is ready for the next set. Registers: digit_passes at 0x0, digit_bits at 0x4.
module lsd_radix_sorter_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsd_pkg::DATA_W-1:0]    s_tdata,   // value
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsd_pkg::DATA_W-1:0]    m_tdata,   // sorted_value
    output logic                          m_tlast,
    output logic                          m_tuser,   // truncated
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsd_pkg::PADDR_W-1:0]   paddr,
    input  logic [lsd_pkg::PDATA_W-1:0]   pwdata,
    output logic [lsd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import lsd_pkg::*;

    logic [VALUE_BITS-1:0] elem_mem [MAX_ITEMS];
    logic [VALUE_BITS-1:0] copy_mem [MAX_ITEMS];
    logic [CNT_W-1:0]      cnt_mem  [MAX_RADIX];

    state_t state_reg, state_next;

    logic [CFG_PASS_W-1:0] cfg_passes_reg;
    logic [CFG_BITS_W-1:0] cfg_bits_reg;

    logic [CNT_W-1:0]      n_reg, n_next;
    logic                  ovf_reg, ovf_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [PASS_W-1:0]     passes_reg, passes_next;
    logic [PASS_W-1:0]     pass_reg, pass_next;
    logic [BITS_W-1:0]     bits_reg, bits_next;
    logic [DIGIT_W-1:0]    mask_reg, mask_next;
    logic [SHIFT_W-1:0]    shift_reg, shift_next;
    logic [DIGIT_W-1:0]    digit_reg, digit_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [CNT_W-1:0]      acc_reg, acc_next;
    logic                  mvalid_reg, mvalid_next;
    logic [DATA_W-1:0]     mdata_reg, mdata_next;
    logic                  mlast_reg, mlast_next;
    logic                  muser_reg, muser_next;

    logic [VALUE_BITS-1:0] elem_rdata_reg, copy_rdata_reg;
    logic [CNT_W-1:0]      cnt_rdata_reg;

    logic                  e_we, c_we, k_we;
    logic [ADDR_W-1:0]     e_waddr, e_raddr, c_waddr, c_raddr;
    logic [VALUE_BITS-1:0] e_wdata, c_wdata;
    logic [DIGIT_W-1:0]    k_waddr, k_raddr;
    logic [CNT_W-1:0]      k_wdata;

    logic [CNT_W-1:0]      alu_a, alu_b, alu_y;
    logic [VALUE_BITS-1:0] shifted;
    logic [DIGIT_W-1:0]    digit;
    logic                  in_acc, cfg_wr;
    logic                  idx_n_last, idx_r_last, idx_zero, pass_done, n_full;
    logic [CNT_W-1:0]      n_m1;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_passes_reg <= CFG_PASS_W'(MAX_PASSES);
            cfg_bits_reg   <= CFG_BITS_W'(DIGIT_W);
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[2]))
                REG_DIGIT_PASSES: cfg_passes_reg <= pwdata[CFG_PASS_W-1:0];
                REG_DIGIT_BITS:   cfg_bits_reg   <= pwdata[CFG_BITS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_DIGIT_PASSES: prdata = PDATA_W'(cfg_passes_reg);
            REG_DIGIT_BITS:   prdata = PDATA_W'(cfg_bits_reg);
            default:          prdata = '0;
        endcase
    end

    // shared datapath
    assign in_acc     = s_tvalid & s_tready;
    assign n_m1       = n_reg - CNT_W'(1);
    assign n_full     = (n_reg == CNT_W'(MAX_ITEMS));
    assign idx_n_last = (idx_reg == IDX_W'(n_m1));
    assign idx_r_last = (idx_reg == IDX_W'(mask_reg));
    assign idx_zero   = (idx_reg == '0);
    assign pass_done  = (PASS_W'(pass_reg + PASS_W'(1)) == passes_reg);
    assign shifted    = elem_rdata_reg >> shift_reg;
    assign digit      = (int'(shift_reg) >= VALUE_BITS) ? '0
                        : (DIGIT_W'(shifted) & mask_reg);
    assign alu_y      = alu_a + alu_b;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_acc && s_tlast) begin
                    state_next = (eff_passes(cfg_passes_reg) == '0) ? ST_EM_RD : ST_CLEAR;
                end
            end
            ST_CLEAR:  state_next = idx_r_last ? ST_CNT_RE : ST_CLEAR;
            ST_CNT_RE: state_next = ST_CNT_RC;
            ST_CNT_RC: state_next = ST_CNT_WR;
            ST_CNT_WR: state_next = idx_n_last ? ST_PFX_RD : ST_CNT_RE;
            ST_PFX_RD: state_next = ST_PFX_WR;
            ST_PFX_WR: state_next = idx_r_last ? ST_SC_RE : ST_PFX_RD;
            ST_SC_RE:  state_next = ST_SC_RC;
            ST_SC_RC:  state_next = ST_SC_WR;
            ST_SC_WR:  state_next = idx_zero ? ST_CP_RD : ST_SC_RE;
            ST_CP_RD:  state_next = ST_CP_WR;
            ST_CP_WR:  state_next = idx_n_last ? ST_PASS : ST_CP_RD;
            ST_PASS:   state_next = pass_done ? ST_EM_RD : ST_CLEAR;
            ST_EM_RD:  state_next = ST_EM_LD;
            ST_EM_LD:  state_next = ST_EM_WAIT;
            ST_EM_WAIT: begin
                if (m_tready) begin
                    state_next = mlast_reg ? ST_LOAD : ST_EM_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs and datapath controls
    always_comb begin
        s_tready    = 1'b0;
        n_next      = n_reg;
        ovf_next    = ovf_reg;
        idx_next    = idx_reg;
        passes_next = passes_reg;
        pass_next   = pass_reg;
        bits_next   = bits_reg;
        mask_next   = mask_reg;
        shift_next  = shift_reg;
        digit_next  = digit_reg;
        val_next    = val_reg;
        acc_next    = acc_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        muser_next  = muser_reg;
        e_we        = 1'b0;
        e_waddr     = idx_reg[ADDR_W-1:0];
        e_wdata     = copy_rdata_reg;
        e_raddr     = idx_reg[ADDR_W-1:0];
        c_we        = 1'b0;
        c_waddr     = alu_y[ADDR_W-1:0];
        c_wdata     = val_reg;
        c_raddr     = idx_reg[ADDR_W-1:0];
        k_we        = 1'b0;
        k_waddr     = digit_reg;
        k_wdata     = alu_y;
        k_raddr     = digit;
        alu_a       = cnt_rdata_reg;
        alu_b       = CNT_W'(1);
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                e_waddr  = n_reg[ADDR_W-1:0];
                e_wdata  = VALUE_BITS'(s_tdata);
                if (in_acc) begin
                    if (n_full) begin
                        ovf_next = 1'b1;
                    end else begin
                        e_we   = 1'b1;
                        n_next = n_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        passes_next = eff_passes(cfg_passes_reg);
                        bits_next   = eff_bits(cfg_bits_reg);
                        mask_next   = digit_mask(eff_bits(cfg_bits_reg));
                        pass_next   = '0;
                        shift_next  = '0;
                        idx_next    = '0;
                    end
                end
            end
            ST_CLEAR: begin
                k_we     = 1'b1;
                k_waddr  = idx_reg[DIGIT_W-1:0];
                k_wdata  = '0;
                idx_next = idx_r_last ? '0 : idx_reg + IDX_W'(1);
            end
            ST_CNT_RC: begin
                digit_next = digit;
            end
            ST_CNT_WR: begin
                k_we     = 1'b1;
                idx_next = idx_n_last ? '0 : idx_reg + IDX_W'(1);
                acc_next = '0;
            end
            ST_PFX_RD: begin
                k_raddr = idx_reg[DIGIT_W-1:0];
            end
            ST_PFX_WR: begin
                alu_a    = acc_reg;
                alu_b    = cnt_rdata_reg;
                k_we     = 1'b1;
                k_waddr  = idx_reg[DIGIT_W-1:0];
                acc_next = alu_y;
                idx_next = idx_r_last ? IDX_W'(n_m1) : idx_reg + IDX_W'(1);
            end
            ST_SC_RC: begin
                digit_next = digit;
                val_next   = elem_rdata_reg;
            end
            ST_SC_WR: begin
                alu_b    = '1;
                k_we     = 1'b1;
                c_we     = 1'b1;
                idx_next = idx_zero ? '0 : idx_reg - IDX_W'(1);
            end
            ST_CP_WR: begin
                e_we     = 1'b1;
                idx_next = idx_n_last ? '0 : idx_reg + IDX_W'(1);
            end
            ST_PASS: begin
                pass_next  = pass_reg + PASS_W'(1);
                shift_next = shift_reg + SHIFT_W'(bits_reg);
                idx_next   = '0;
            end
            ST_EM_LD: begin
                mvalid_next = 1'b1;
                mdata_next  = DATA_W'(elem_rdata_reg);
                mlast_next  = idx_n_last;
                muser_next  = ovf_reg;
            end
            ST_EM_WAIT: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    if (mlast_reg) begin
                        n_next   = '0;
                        ovf_next = 1'b0;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            n_reg      <= '0;
            ovf_reg    <= 1'b0;
            idx_reg    <= '0;
            pass_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            ovf_reg    <= ovf_next;
            idx_reg    <= idx_next;
            pass_reg   <= pass_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        passes_reg <= passes_next;
        bits_reg   <= bits_next;
        mask_reg   <= mask_next;
        shift_reg  <= shift_next;
        digit_reg  <= digit_next;
        val_reg    <= val_next;
        acc_reg    <= acc_next;
        mdata_reg  <= mdata_next;
        mlast_reg  <= mlast_next;
        muser_reg  <= muser_next;
    end

    // memories
    always_ff @(posedge aclk) begin
        if (e_we) begin
            elem_mem[e_waddr] <= e_wdata;
        end
        elem_rdata_reg <= elem_mem[e_raddr];
    end

    always_ff @(posedge aclk) begin
        if (c_we) begin
            copy_mem[c_waddr] <= c_wdata;
        end
        copy_rdata_reg <= copy_mem[c_raddr];
    end

    always_ff @(posedge aclk) begin
        if (k_we) begin
            cnt_mem[k_waddr] <= k_wdata;
        end
        cnt_rdata_reg <= cnt_mem[k_raddr];
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

    // checks
    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input taken while output pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_ovf_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> n_reg == CNT_W'(MAX_ITEMS))
        else $error("overflow flag without full store");

    a_run_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (n_reg == '0 && !ovf_reg && s_tready))
        else $error("store not emptied after run");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> n_reg != '0)
        else $error("output word from empty store");

endmodule
